>>> sv/tkst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_pkg: shared types and constants of the top-k sorted table
// Operation and status codes, field widths, the entry record and the
// control group broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package tkst_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int FUNC_W   = 2;
  localparam int KEY_HI_W = 64;
  localparam int KEY_LO_W = 32;
  localparam int SIZE_W   = 32;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int FOUND_W  = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_DELETE = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE  = 2'd0,
    STS_RANGE = 2'd1,
    STS_DROP  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_SHIFT = 1'b1
  } state_t;

  typedef struct packed {
    logic [KEY_HI_W-1:0] key_high;
    logic [KEY_LO_W-1:0] key_low;
    logic [SIZE_W-1:0]   size;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic del_en;
    logic rd_load;
    logic rd_shift;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/tkst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_if: request and response channels of the top-k sorted table
// Valid/ready channels; a transaction moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface tkst_req_if;
  logic                         valid;
  logic                         ready;
  logic [tkst_pkg::FUNC_W-1:0]   func;
  logic [tkst_pkg::KEY_HI_W-1:0] key_high;
  logic [tkst_pkg::KEY_LO_W-1:0] key_low;
  logic [tkst_pkg::SIZE_W-1:0]   item_size;
  logic [tkst_pkg::INDEX_W-1:0]  index;

  modport source (output valid, func, key_high, key_low, item_size, index, input ready);
  modport sink   (input valid, func, key_high, key_low, item_size, index, output ready);
endinterface

interface tkst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tkst_pkg::STATUS_W-1:0] status;
  logic [tkst_pkg::COUNT_W-1:0]  count;
  logic [tkst_pkg::FOUND_W-1:0]  found_count;
  logic [tkst_pkg::KEY_HI_W-1:0] out_key_high;
  logic [tkst_pkg::KEY_LO_W-1:0] out_key_low;
  logic [tkst_pkg::SIZE_W-1:0]   out_size;

  modport source (output valid, status, count, found_count, out_key_high, out_key_low,
                  out_size, input ready);
  modport sink   (input valid, status, count, found_count, out_key_high, out_key_low,
                  out_size, output ready);
endinterface
`default_nettype wire

>>> sv/tkst_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tkst_cell: one position of the sorted chain
// Holds one entry, compares it with a new key, takes from its left neighbour
// on insert or its right neighbour on delete, and shifts a read copy leftward.
// ----------------------------------------------------------------------------
module tkst_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 7
) (
  input  wire                           clk,
  input  wire tkst_pkg::cell_ctrl_t     ctrl,
  input  wire [CNT_W-1:0]               count_i,
  input  wire [tkst_pkg::INDEX_W-1:0]   del_idx,
  input  wire tkst_pkg::entry_t         new_ent,
  input  wire tkst_pkg::entry_t         left_ent,
  input  wire                           left_take,
  input  wire tkst_pkg::entry_t         right_ent,
  input  wire tkst_pkg::entry_t         right_rd,
  output tkst_pkg::entry_t              ent_o,
  output logic                          take_o,
  output tkst_pkg::entry_t              rd_o
);

  tkst_pkg::entry_t ent_r, ent_nxt;
  tkst_pkg::entry_t rd_r, rd_nxt;
  logic             valid;
  logic             greater;
  logic             at_or_after;

  assign valid       = 32'(POS) < 32'(count_i);
  assign greater     = {new_ent.key_high, new_ent.key_low} > {ent_r.key_high, ent_r.key_low};
  // empty cells and cells with a smaller key want the new entry or its shift
  assign take_o      = !valid || greater;
  assign at_or_after = 32'(POS) >= 32'(del_idx);

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins_en) begin
      if (left_take) begin
        ent_nxt = left_ent;
      end else if (take_o) begin
        ent_nxt = new_ent;
      end
    end else if (ctrl.del_en && at_or_after) begin
      ent_nxt = right_ent;
    end
  end

  always_comb begin
    rd_nxt = rd_r;
    if (ctrl.rd_load) begin
      rd_nxt = ent_r;
    end else if (ctrl.rd_shift) begin
      rd_nxt = right_rd;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    rd_r  <= rd_nxt;
  end

  assign ent_o = ent_r;
  assign rd_o  = rd_r;

endmodule
`default_nettype wire

>>> sv/top_k_sorted_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// top_k_sorted_table: keeps the largest keys in descending order
// Chain of cells, one per table position, with a small controller.
// ----------------------------------------------------------------------------
// Clear, insert and delete complete in the cycle the request transaction is
// taken, all cells comparing and shifting together, so the response is ready
// on the next cycle. A read of position n copies the table into the read
// registers of the chain and shifts it toward position 0 one cell a cycle,
// then waits for a free response register. One request is handled at a time;
// a new request is taken while the previous response still waits, as long as
// the response register frees up in the same cycle. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module top_k_sorted_table #(
  parameter int ENTRIES = tkst_pkg::ENTRIES_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  tkst_req_if.sink     in_ch,
  tkst_rsp_if.source   out_ch
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  tkst_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [tkst_pkg::FOUND_W-1:0] found_r, found_nxt;
  logic [tkst_pkg::INDEX_W-1:0] rd_cnt_r, rd_cnt_nxt;

  logic                 out_valid_r, out_valid_nxt;
  tkst_pkg::status_t    out_status_r, out_status_nxt;
  logic [tkst_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [tkst_pkg::FOUND_W-1:0] out_found_r, out_found_nxt;
  tkst_pkg::entry_t     out_ent_r, out_ent_nxt;
  logic                 load_out;

  tkst_pkg::cell_ctrl_t ctrl;
  tkst_pkg::entry_t     new_ent;
  tkst_pkg::entry_t     ent_w  [ENTRIES];
  tkst_pkg::entry_t     rd_w   [ENTRIES];
  logic                 take_w [ENTRIES];

  logic in_acc;
  logic out_free;
  logic idx_ok;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == tkst_pkg::S_IDLE) && out_free;
  assign idx_ok   = 32'(in_ch.index) < 32'(count_r);

  assign new_ent.key_high = in_ch.key_high;
  assign new_ent.key_low  = in_ch.key_low;
  assign new_ent.size     = in_ch.item_size;

  // the chain
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    tkst_pkg::entry_t left_ent, right_ent, right_rd;
    logic             left_take;

    if (g == 0) begin : g_first
      assign left_ent  = '0;
      assign left_take = 1'b0;
    end else begin : g_mid_l
      assign left_ent  = ent_w[g-1];
      assign left_take = take_w[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign right_ent = '0;
      assign right_rd  = '0;
    end else begin : g_mid_r
      assign right_ent = ent_w[g+1];
      assign right_rd  = rd_w[g+1];
    end

    tkst_cell #(
      .POS   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count_i   (count_r),
      .del_idx   (in_ch.index),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .left_take (left_take),
      .right_ent (right_ent),
      .right_rd  (right_rd),
      .ent_o     (ent_w[g]),
      .take_o    (take_w[g]),
      .rd_o      (rd_w[g])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    found_nxt      = found_r;
    rd_cnt_nxt     = rd_cnt_r;
    ctrl           = '0;
    load_out       = 1'b0;
    out_status_nxt = tkst_pkg::STS_DONE;
    out_ent_nxt    = '0;

    case (state_r)
      tkst_pkg::S_IDLE: begin
        if (in_acc) begin
          case (tkst_pkg::func_t'(in_ch.func))
            tkst_pkg::FN_CLEAR: begin
              count_nxt = '0;
              found_nxt = '0;
              load_out  = 1'b1;
            end
            tkst_pkg::FN_INSERT: begin
              load_out    = 1'b1;
              ctrl.ins_en = 1'b1;
              if (found_r != '1) begin
                found_nxt = found_r + 1'b1;
              end
              // last cell refuses only when full and its key is not smaller
              if (take_w[ENTRIES-1]) begin
                if (count_r != CNT_W'(ENTRIES)) begin
                  count_nxt = count_r + 1'b1;
                end
              end else begin
                out_status_nxt = tkst_pkg::STS_DROP;
              end
            end
            tkst_pkg::FN_DELETE: begin
              load_out = 1'b1;
              if (idx_ok) begin
                ctrl.del_en = 1'b1;
                count_nxt   = count_r - 1'b1;
                if (found_r != '0) begin
                  found_nxt = found_r - 1'b1;
                end
              end else begin
                out_status_nxt = tkst_pkg::STS_RANGE;
              end
            end
            tkst_pkg::FN_READ: begin
              if (idx_ok) begin
                ctrl.rd_load = 1'b1;
                rd_cnt_nxt   = in_ch.index;
                state_nxt    = tkst_pkg::S_SHIFT;
              end else begin
                load_out       = 1'b1;
                out_status_nxt = tkst_pkg::STS_RANGE;
              end
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      tkst_pkg::S_SHIFT: begin
        if (rd_cnt_r == '0) begin
          if (out_free) begin
            load_out    = 1'b1;
            out_ent_nxt = rd_w[0];
            state_nxt   = tkst_pkg::S_IDLE;
          end
        end else begin
          ctrl.rd_shift = 1'b1;
          rd_cnt_nxt    = rd_cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = tkst_pkg::S_IDLE;
      end
    endcase
  end

  assign out_count_nxt = tkst_pkg::COUNT_W'(count_nxt);
  assign out_found_nxt = found_nxt;
  assign out_valid_nxt = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tkst_pkg::S_IDLE;
      count_r     <= '0;
      found_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      found_r     <= found_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
      out_found_r  <= out_found_nxt;
      out_ent_r    <= out_ent_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.count        = out_count_r;
  assign out_ch.found_count  = out_found_r;
  assign out_ch.out_key_high = out_ent_r.key_high;
  assign out_ch.out_key_low  = out_ent_r.key_low;
  assign out_ch.out_size     = out_ent_r.size;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("entry count above table size");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.func == tkst_pkg::FN_CLEAR) |=> (count_r == '0) && (found_r == '0))
    else $error("clear did not empty the table");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.func == tkst_pkg::FN_INSERT) && !take_w[ENTRIES-1]
      |-> count_r == CNT_W'(ENTRIES))
    else $error("insert dropped with room left");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_ch.func == tkst_pkg::FN_DELETE) && idx_ok
      |=> count_r == $past(count_r) - 1'b1)
    else $error("delete did not shrink the table");

  a_read_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tkst_pkg::S_SHIFT) && (rd_cnt_r != '0)
      |=> (state_r == tkst_pkg::S_SHIFT) && (rd_cnt_r == $past(rd_cnt_r) - 1'b1))
    else $error("read shift lost its place");

endmodule
`default_nettype wire
